[src/lcc_pkg.sv]
// Shared types, constants and the arctangent table of the command conditioner.
package lcc_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN       = 24;
    localparam int RUN_STAGES    = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int SQRT_STAGES   = 16;
    // atan2 span: one pre-rotation stage plus the micro-rotations, at least the root span
    localparam int LOOP_STAGES   = (RUN_STAGES + 1 > SQRT_STAGES) ? RUN_STAGES + 1
                                                                   : SQRT_STAGES;
    localparam int SC_STAGES     = RUN_STAGES + 7;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 80;
    localparam int CFG_W      = 15;

    typedef logic signed [27:0] ang_t;   // Q.24 radians
    typedef logic signed [35:0] vec_t;   // vectoring x/y
    typedef logic signed [32:0] arg_t;   // unreduced angle, Q.24
    typedef logic signed [17:0] head_t;  // Q3.13 heading with headroom

    localparam ang_t ANG_PI      = 28'sd52707179;
    localparam ang_t ANG_TWO_PI  = 28'sd105414357;
    localparam ang_t ANG_HALF_PI = 28'sd26353589;
    localparam logic [27:0] TWO_PI_U = 28'd105414357;

    localparam head_t HEAD_PI     = 18'sd25736;
    localparam head_t HEAD_TWO_PI = 18'sd51472;

    localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;

    // floor(2^58 / 2pi) in Q.24 units
    localparam int RECIP_SHIFT = 58;
    localparam logic [31:0] RECIP_2PI = 32'd2734261104;

    typedef enum logic [1:0] {
        GAIT_IDLE = 2'd0,
        GAIT_SLOW = 2'd1,
        GAIT_WALK = 2'd2
    } gait_t;

    localparam logic [1:0] CFG_IDLE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_WALK_LIMIT = 2'd1;
    localparam logic [1:0] CFG_FACE_LEAD  = 2'd2;

    function automatic ang_t arc_tab(input int i);
        case (i)
            0:  return 28'sd13176795;
            1:  return 28'sd7778716;
            2:  return 28'sd4110060;
            3:  return 28'sd2086331;
            4:  return 28'sd1047214;
            5:  return 28'sd524117;
            6:  return 28'sd262123;
            7:  return 28'sd131069;
            8:  return 28'sd65536;
            9:  return 28'sd32768;
            10: return 28'sd16384;
            11: return 28'sd8192;
            12: return 28'sd4096;
            13: return 28'sd2048;
            14: return 28'sd1024;
            15: return 28'sd512;
            16: return 28'sd256;
            17: return 28'sd128;
            18: return 28'sd64;
            19: return 28'sd32;
            20: return 28'sd16;
            21: return 28'sd8;
            22: return 28'sd4;
            23: return 28'sd2;
            default: return '0;
        endcase
    endfunction

endpackage

[src/locomotion_command_conditioner.sv]
// Top level: heading, speed, gait and course/facing cosine and sine pipeline.
//
//  port group  | dir | fields (low bit first)
//  s_*         | in  | tdata: cmd_vx, cmd_vy, cmd_yaw_rate, quat_w..z, ref/start heading;
//              |     | tuser: first_plan
//  m_*         | out | tdata: target_speed, move_cos, move_sin, face_cos, face_sin;
//              |     | tuser: gait_mode
//  cfg_*       | in  | register write: 0 idle limit, 1 walk limit, 2 face lead time
//
// One item per cycle; LOOP_STAGES + SC_STAGES + 8 register stages (48 with 16 CORDIC
// stages); the depth is set by the atan2/root span followed by the reduction and
// rotation span.
// Reset clears the valid bits and loads the register defaults.
// The whole pipeline holds while the output register is full and not taken.
module locomotion_command_conditioner (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lcc_pkg::IN_DATA_W-1:0]     s_tdata,   // vx, vy, yaw_rate, qw, qx, qy, qz, ref, start
    input  logic                              s_tuser,   // first_plan
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lcc_pkg::OUT_DATA_W-1:0]    m_tdata,   // speed, move_cos, move_sin, face_cos, face_sin
    output logic [1:0]                        m_tuser,   // gait_mode
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_addr,
    input  logic [lcc_pkg::CFG_W-1:0]         cfg_wdata
);
    import lcc_pkg::*;

    localparam int P1  = 3 + LOOP_STAGES;
    localparam int P4  = P1 + 3;
    localparam int VLD = P4 + SC_STAGES + 2;

    typedef struct packed {
        logic               first;
        logic signed [15:0] ref_h;
        logic signed [15:0] start_h;
        logic signed [31:0] wfl;
    } side_t;

    typedef struct packed {
        logic        first;
        logic        stepping;
        gait_t       mode;
        logic [15:0] speed;
    } tail_t;

    logic                 en;
    logic                 vld_reg [VLD];

    logic [CFG_W-1:0]     idle_reg;
    logic [CFG_W-1:0]     walk_reg;
    logic [CFG_W-1:0]     lead_reg;

    // input stage
    logic signed [15:0]   vx_reg, vy_reg, wr_reg, qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [15:0]   ref0_reg, start0_reg;
    logic                 first0_reg;
    // products
    logic signed [31:0]   pwz_reg, pxy_reg, pyy_reg, pzz_reg, pvx_reg, pvy_reg, wfl1_reg;
    logic signed [15:0]   vx1_reg, vy1_reg, ref1_reg, start1_reg;
    logic                 first1_reg;
    // sums, atan2 inputs
    vec_t                 num_reg, den_reg, cy_reg, cx_reg;
    side_t                sd_reg  [LOOP_STAGES+1];
    logic [31:0]          sqn_reg [LOOP_STAGES+1];
    logic [31:0]          sqr_reg [LOOP_STAGES+1];
    ang_t                 zy, zc;
    // heading stages
    head_t                yaw1_reg, yaw2_reg, d2_reg, psi3_reg;
    ang_t                 zc1_reg, zc2_reg, zc3_reg;
    side_t                sd1_reg, sd2_reg;
    logic signed [31:0]   wfl3_reg;
    tail_t                tl1_reg, tl2_reg, tl3_reg;
    arg_t                 course4_reg, facing4_reg;
    tail_t                tl_reg [SC_STAGES+1];
    logic signed [15:0]   mc, ms, fc, fs;
    // output register
    logic [1:0]           gait_reg;
    logic [15:0]          speed_reg;
    logic signed [15:0]   mc_reg, ms_reg, fc_reg, fs_reg;

    logic [15:0]          speed_p;
    logic                 step_p;
    head_t                dd;
    head_t                yaw_p;
    arg_t                 psi_sh;

    assign en       = !vld_reg[VLD-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg <= 15'd491;
            walk_reg <= 15'd3277;
            lead_reg <= 15'd2458;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_IDLE_LIMIT: idle_reg <= cfg_wdata;
                CFG_WALK_LIMIT: walk_reg <= cfg_wdata;
                CFG_FACE_LEAD:  lead_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VLD; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < VLD; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg     <= s_tdata[15:0];
            vy_reg     <= s_tdata[31:16];
            wr_reg     <= s_tdata[47:32];
            qw_reg     <= s_tdata[63:48];
            qx_reg     <= s_tdata[79:64];
            qy_reg     <= s_tdata[95:80];
            qz_reg     <= s_tdata[111:96];
            ref0_reg   <= s_tdata[127:112];
            start0_reg <= s_tdata[143:128];
            first0_reg <= s_tuser;

            pwz_reg    <= 32'(qw_reg) * 32'(qz_reg);
            pxy_reg    <= 32'(qx_reg) * 32'(qy_reg);
            pyy_reg    <= 32'(qy_reg) * 32'(qy_reg);
            pzz_reg    <= 32'(qz_reg) * 32'(qz_reg);
            pvx_reg    <= 32'(vx_reg) * 32'(vx_reg);
            pvy_reg    <= 32'(vy_reg) * 32'(vy_reg);
            wfl1_reg   <= 32'(wr_reg) * 32'($signed({1'b0, lead_reg}));
            vx1_reg    <= vx_reg;
            vy1_reg    <= vy_reg;
            ref1_reg   <= ref0_reg;
            start1_reg <= start0_reg;
            first1_reg <= first0_reg;

            // yaw = atan2(2(wz+xy), 1-2(y^2+z^2)) in Q28
            num_reg    <= (36'(pwz_reg) + 36'(pxy_reg)) <<< 1;
            den_reg    <= 36'sd268435456 - ((36'(pyy_reg) + 36'(pzz_reg)) <<< 1);
            cy_reg     <= {{6{vy1_reg[15]}}, vy1_reg, 14'd0};
            cx_reg     <= {{6{vx1_reg[15]}}, vx1_reg, 14'd0};
            sqn_reg[0] <= 32'(pvx_reg) + 32'(pvy_reg);
            sqr_reg[0] <= '0;
            sd_reg[0]  <= '{first: first1_reg, ref_h: ref1_reg, start_h: start1_reg,
                            wfl: wfl1_reg};
        end
    end

    lcc_atan2 u_yaw (
        .clk   (clk),
        .en    (en),
        .y_in  (num_reg),
        .x_in  (den_reg),
        .z_out (zy)
    );

    lcc_atan2 u_course (
        .clk   (clk),
        .en    (en),
        .y_in  (cy_reg),
        .x_in  (cx_reg),
        .z_out (zc)
    );

    // bit-serial floor square root, one result bit per stage, aligned to the atan2 span
    for (genvar k = 1; k <= LOOP_STAGES; k++)
    begin : g_sqrt
        localparam int OFS = k - 1 - (LOOP_STAGES - SQRT_STAGES);
        if (OFS >= 0)
        begin : g_bit
            localparam logic [31:0] B = 32'd1 << (2 * (SQRT_STAGES - 1 - OFS));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sd_reg[k] <= sd_reg[k-1];
                    if (sqn_reg[k-1] >= sqr_reg[k-1] + B)
                    begin
                        sqn_reg[k] <= sqn_reg[k-1] - (sqr_reg[k-1] + B);
                        sqr_reg[k] <= (sqr_reg[k-1] >> 1) + B;
                    end
                    else
                    begin
                        sqn_reg[k] <= sqn_reg[k-1];
                        sqr_reg[k] <= sqr_reg[k-1] >> 1;
                    end
                end
            end
        end
        else
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sd_reg[k]  <= sd_reg[k-1];
                    sqn_reg[k] <= sqn_reg[k-1];
                    sqr_reg[k] <= sqr_reg[k-1];
                end
            end
        end
    end

    assign speed_p = sqr_reg[LOOP_STAGES][15:0];
    assign step_p  = speed_p > {1'b0, idle_reg};
    assign yaw_p   = 18'((29'(zy) + 29'sd1024) >>> 11);
    assign dd      = yaw1_reg - head_t'(sd1_reg.start_h);
    assign psi_sh  = {{4{psi3_reg[17]}}, psi3_reg, 11'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw1_reg <= yaw_p;
            zc1_reg  <= zc;
            sd1_reg  <= sd_reg[LOOP_STAGES];
            tl1_reg  <= '{first: sd_reg[LOOP_STAGES].first, stepping: step_p,
                          mode: !step_p ? GAIT_IDLE :
                                (speed_p < {1'b0, walk_reg}) ? GAIT_SLOW : GAIT_WALK,
                          speed: speed_p};

            // yaw change since plan start, wrapped to [-pi, pi]
            if (dd > HEAD_PI)
                d2_reg <= dd - HEAD_TWO_PI;
            else if (dd < -HEAD_PI)
                d2_reg <= dd + HEAD_TWO_PI;
            else
                d2_reg <= dd;
            yaw2_reg <= yaw1_reg;
            zc2_reg  <= zc1_reg;
            sd2_reg  <= sd1_reg;
            tl2_reg  <= tl1_reg;

            psi3_reg <= sd2_reg.first ? yaw2_reg : head_t'(sd2_reg.ref_h) + d2_reg;
            zc3_reg  <= zc2_reg;
            wfl3_reg <= sd2_reg.wfl;
            tl3_reg  <= tl2_reg;

            course4_reg <= psi_sh + arg_t'(zc3_reg);
            facing4_reg <= psi_sh + arg_t'(wfl3_reg);
            tl_reg[0]   <= tl3_reg;

            for (int i = 1; i <= SC_STAGES; i++)
                tl_reg[i] <= tl_reg[i-1];
        end
    end

    lcc_sincos u_move (
        .clk   (clk),
        .en    (en),
        .a_in  (course4_reg),
        .c_out (mc),
        .s_out (ms)
    );

    lcc_sincos u_face (
        .clk   (clk),
        .en    (en),
        .a_in  (facing4_reg),
        .c_out (fc),
        .s_out (fs)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gait_reg  <= tl_reg[SC_STAGES].first ? GAIT_IDLE : tl_reg[SC_STAGES].mode;
            speed_reg <= (tl_reg[SC_STAGES].first || !tl_reg[SC_STAGES].stepping) ?
                         16'd0 : tl_reg[SC_STAGES].speed;
            mc_reg    <= tl_reg[SC_STAGES].stepping ? mc : 16'sd0;
            ms_reg    <= tl_reg[SC_STAGES].stepping ? ms : 16'sd0;
            fc_reg    <= fc;
            fs_reg    <= fs;
        end
    end

    assign m_tvalid = vld_reg[VLD-1];
    assign m_tdata  = {fs_reg, fc_reg, ms_reg, mc_reg, speed_reg};
    assign m_tuser  = gait_reg;

    // an idle gait goes with zero speed, a moving gait with a nonzero speed
    a_gait_speed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == GAIT_IDLE) == (m_tdata[15:0] == 16'd0)))
        else $error("gait mode and target speed disagree");

    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[63:48]) <= 16'sd16384 &&
                      $signed(m_tdata[63:48]) >= -16'sd16384 &&
                      $signed(m_tdata[79:64]) <= 16'sd16384 &&
                      $signed(m_tdata[79:64]) >= -16'sd16384))
        else $error("facing cosine or sine out of range");

    a_move_live: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != GAIT_IDLE) |->
            (m_tdata[31:16] != 16'd0 || m_tdata[47:32] != 16'd0))
        else $error("moving item without a course vector");

endmodule

[src/lcc_atan2.sv]
// Pipelined vectoring CORDIC: atan2(y, x) in Q.24 radians.
module lcc_atan2 (
    input  logic         clk,
    input  logic         en,
    input  lcc_pkg::vec_t y_in,
    input  lcc_pkg::vec_t x_in,
    output lcc_pkg::ang_t z_out
);
    import lcc_pkg::*;

    vec_t x_reg    [LOOP_STAGES];
    vec_t y_reg    [LOOP_STAGES];
    ang_t z_reg    [LOOP_STAGES];
    logic zero_reg [LOOP_STAGES];

    // left half plane is rotated by pi first
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                z_reg[0] <= (y_in >= 0) ? ANG_PI : -ANG_PI;
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
            end
            else
            begin
                z_reg[0] <= '0;
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
            end
        end
    end

    for (genvar k = 1; k < LOOP_STAGES; k++)
    begin : g_stage
        if (k - 1 < RUN_STAGES)
        begin : g_rot
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[k] <= zero_reg[k-1];
                    if (y_reg[k-1] > 0)
                    begin
                        x_reg[k] <= x_reg[k-1] + (y_reg[k-1] >>> (k - 1));
                        y_reg[k] <= y_reg[k-1] - (x_reg[k-1] >>> (k - 1));
                        z_reg[k] <= z_reg[k-1] + arc_tab(k - 1);
                    end
                    else
                    begin
                        x_reg[k] <= x_reg[k-1] - (y_reg[k-1] >>> (k - 1));
                        y_reg[k] <= y_reg[k-1] + (x_reg[k-1] >>> (k - 1));
                        z_reg[k] <= z_reg[k-1] - arc_tab(k - 1);
                    end
                end
            end
        end
        else
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[k] <= zero_reg[k-1];
                    x_reg[k]    <= x_reg[k-1];
                    y_reg[k]    <= y_reg[k-1];
                    z_reg[k]    <= z_reg[k-1];
                end
            end
        end
    end

    assign z_out = zero_reg[LOOP_STAGES-1] ? '0 : z_reg[LOOP_STAGES-1];

endmodule

[src/lcc_sincos.sv]
// Pipelined angle reduction and rotation CORDIC giving Q1.14 cosine and sine.
module lcc_sincos (
    input  logic                clk,
    input  logic                en,
    input  lcc_pkg::arg_t       a_in,
    output logic signed [15:0]  c_out,
    output logic signed [15:0]  s_out
);
    import lcc_pkg::*;

    localparam int Q_W = 64 - RECIP_SHIFT;

    logic [31:0]            m0_reg;
    logic                   n0_reg;
    logic [Q_W-1:0]         q1_reg;
    logic [31:0]            m1_reg;
    logic                   n1_reg;
    logic [27:0]            r2_reg;
    logic                   n2_reg;
    ang_t                   a3_reg;
    ang_t                   a4_reg;
    logic signed [31:0]     rx_reg [RUN_STAGES+1];
    logic signed [31:0]     ry_reg [RUN_STAGES+1];
    ang_t                   ra_reg [RUN_STAGES+1];
    logic                   rf_reg [RUN_STAGES+1];
    logic signed [15:0]     c_reg;
    logic signed [15:0]     s_reg;

    logic [63:0]            prod;
    logic [32:0]            qt;
    logic [32:0]            r2;
    logic [27:0]            r3;
    logic signed [31:0]     xs;
    logic signed [31:0]     ys;
    logic signed [17:0]     xf;
    logic signed [17:0]     yf;

    function automatic logic signed [15:0] sat14(input logic signed [17:0] v);
        if (v > 18'sd16384)
            return 16'sd16384;
        else if (v < -18'sd16384)
            return -16'sd16384;
        else
            return v[15:0];
    endfunction

    assign prod = 64'(m0_reg) * 64'(RECIP_2PI);
    assign qt   = 33'(q1_reg) * 33'(TWO_PI_U);
    assign r2   = 33'(m1_reg) - qt;
    assign r3   = (r2_reg >= TWO_PI_U) ? r2_reg - TWO_PI_U : r2_reg;

    // truncating remainder: work on the magnitude, restore the sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg <= a_in[32] ? 32'(-a_in) : 32'(a_in);
            n0_reg <= a_in[32];
            q1_reg <= prod[63:RECIP_SHIFT];
            m1_reg <= m0_reg;
            n1_reg <= n0_reg;
            r2_reg <= r2[27:0];
            n2_reg <= n1_reg;
            a3_reg <= n2_reg ? -ang_t'(r3) : ang_t'(r3);
            if (a3_reg > ANG_PI)
                a4_reg <= a3_reg - ANG_TWO_PI;
            else if (a3_reg < -ANG_PI)
                a4_reg <= a3_reg + ANG_TWO_PI;
            else
                a4_reg <= a3_reg;
            rx_reg[0] <= INV_GAIN_Q30;
            ry_reg[0] <= '0;
            if (a4_reg > ANG_HALF_PI)
            begin
                ra_reg[0] <= a4_reg - ANG_PI;
                rf_reg[0] <= 1'b1;
            end
            else if (a4_reg < -ANG_HALF_PI)
            begin
                ra_reg[0] <= a4_reg + ANG_PI;
                rf_reg[0] <= 1'b1;
            end
            else
            begin
                ra_reg[0] <= a4_reg;
                rf_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar k = 1; k <= RUN_STAGES; k++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rf_reg[k] <= rf_reg[k-1];
                if (ra_reg[k-1] >= 0)
                begin
                    rx_reg[k] <= rx_reg[k-1] - (ry_reg[k-1] >>> (k - 1));
                    ry_reg[k] <= ry_reg[k-1] + (rx_reg[k-1] >>> (k - 1));
                    ra_reg[k] <= ra_reg[k-1] - arc_tab(k - 1);
                end
                else
                begin
                    rx_reg[k] <= rx_reg[k-1] + (ry_reg[k-1] >>> (k - 1));
                    ry_reg[k] <= ry_reg[k-1] - (rx_reg[k-1] >>> (k - 1));
                    ra_reg[k] <= ra_reg[k-1] + arc_tab(k - 1);
                end
            end
        end
    end

    assign xs = (rx_reg[RUN_STAGES] + 32'sd32768) >>> 16;
    assign ys = (ry_reg[RUN_STAGES] + 32'sd32768) >>> 16;
    assign xf = rf_reg[RUN_STAGES] ? -xs[17:0] : xs[17:0];
    assign yf = rf_reg[RUN_STAGES] ? -ys[17:0] : ys[17:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= sat14(xf);
            s_reg <= sat14(yf);
        end
    end

    assign c_out = c_reg;
    assign s_out = s_reg;

endmodule
